@@ rtl/utf8d_pkg.sv @@
// ----------------------------------------------------------------------------
// utf8d_pkg
// Types and constants shared by the UTF-8 decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8d_pkg;

    localparam int unsigned UTF8D_CPW     = 21;
    localparam int unsigned UTF8D_PAW     = 3;
    localparam int unsigned UTF8D_PDW     = 32;
    localparam int unsigned UTF8D_QDEPTH  = 4;
    localparam int unsigned UTF8D_QAW     = $clog2(UTF8D_QDEPTH);

    localparam logic [UTF8D_CPW-1:0] UTF8D_REPL_RST = 21'h00FFFD;

    // register index, taken from paddr[2]
    localparam logic REG_REPLACEMENT = 1'b0;

    // byte class worked out by the front end
    typedef enum logic [3:0] {
        CLS_ASCII,
        CLS_CONT,
        CLS_C0C1,
        CLS_LEAD2,
        CLS_E0,
        CLS_ED,
        CLS_LEAD3,
        CLS_F0,
        CLS_LEAD4,
        CLS_F4,
        CLS_F5F7,
        CLS_F8FB,
        CLS_FCFD,
        CLS_FEFF,
        CLS_EOS
    } t_cls;

    typedef struct packed {
        t_cls       cls;
        logic [7:0] data_byte;
    } t_qent;

    typedef enum logic [3:0] {
        MODE_START = 4'd0,
        MODE_ERR1  = 4'd1,
        MODE_ERR2  = 4'd2,
        MODE_ERR3  = 4'd3,
        MODE_ERR4  = 4'd4,
        MODE_ERR5  = 4'd5,
        MODE_APP1  = 4'd6,
        MODE_APP2  = 4'd7,
        MODE_APP3  = 4'd8,
        MODE_E0    = 4'd9,
        MODE_ED    = 4'd10,
        MODE_F0    = 4'd11,
        MODE_F4    = 4'd12
    } t_mode;

endpackage

`default_nettype wire

@@ rtl/utf8d_ifs.sv @@
// ----------------------------------------------------------------------------
// utf8d_ifs
// Valid/ready channels: raw byte items in, code point items out.
// ----------------------------------------------------------------------------
`default_nettype none

interface utf8d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface utf8d_cp_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic        is_error;
    logic        last_of_run;

    modport source (output valid, output code_point, output is_error, output last_of_run,
                    input ready);
    modport sink   (input valid, input code_point, input is_error, input last_of_run,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/utf8d_front.sv @@
// ----------------------------------------------------------------------------
// utf8d_front
// Accepts byte items and tags each with its UTF-8 byte class.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_front (
    utf8d_byte_if.sink          i_byte_if,
    input  wire logic           i_q_ready,
    output logic                o_q_push,
    output utf8d_pkg::t_qent    o_q_ent
);
    import utf8d_pkg::*;

    t_cls w_cls;

    always_comb begin
        case (i_byte_if.data_byte) inside
            [8'h00:8'h7F]: w_cls = CLS_ASCII;
            [8'h80:8'hBF]: w_cls = CLS_CONT;
            [8'hC0:8'hC1]: w_cls = CLS_C0C1;
            [8'hC2:8'hDF]: w_cls = CLS_LEAD2;
            8'hE0:         w_cls = CLS_E0;
            8'hED:         w_cls = CLS_ED;
            [8'hE1:8'hEF]: w_cls = CLS_LEAD3;
            8'hF0:         w_cls = CLS_F0;
            [8'hF1:8'hF3]: w_cls = CLS_LEAD4;
            8'hF4:         w_cls = CLS_F4;
            [8'hF5:8'hF7]: w_cls = CLS_F5F7;
            [8'hF8:8'hFB]: w_cls = CLS_F8FB;
            [8'hFC:8'hFD]: w_cls = CLS_FCFD;
            default:       w_cls = CLS_FEFF;
        endcase
        if (i_byte_if.end_of_stream) begin
            w_cls = CLS_EOS;
        end
    end

    assign i_byte_if.ready   = i_q_ready;
    assign o_q_push          = i_byte_if.valid && i_q_ready;
    assign o_q_ent.cls       = w_cls;
    assign o_q_ent.data_byte = i_byte_if.data_byte;

endmodule

`default_nettype wire

@@ rtl/utf8d_queue.sv @@
// ----------------------------------------------------------------------------
// utf8d_queue
// Short FIFO of classified items between the front end and the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire utf8d_pkg::t_qent   i_ent,
    output logic                    o_ready,
    input  wire logic               i_pop,
    output logic                    o_valid,
    output utf8d_pkg::t_qent        o_ent
);
    import utf8d_pkg::*;

    t_qent                 r_mem [UTF8D_QDEPTH];
    logic [UTF8D_QAW-1:0]  r_wr_ptr;
    logic [UTF8D_QAW-1:0]  r_rd_ptr;
    logic [UTF8D_QAW:0]    r_count;

    logic w_push;
    logic w_pop;

    assign o_ready = (r_count != (UTF8D_QAW+1)'(UTF8D_QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_ent   = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/utf8d_back.sv @@
// ----------------------------------------------------------------------------
// utf8d_back
// Decode state machine: takes classified items, gathers code point bits and
// produces up to two results per item through an output register and a
// one-entry hold stage.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_back (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic [utf8d_pkg::UTF8D_CPW-1:0]    i_repl,
    input  wire logic                               i_q_valid,
    input  wire utf8d_pkg::t_qent                   i_q_ent,
    output logic                                    o_q_pop,
    utf8d_cp_if.source                              o_cp_if
);
    import utf8d_pkg::*;

    t_mode                r_mode,  n_mode;
    logic [UTF8D_CPW-1:0] r_pv,    n_pv;

    logic                 r_out_vld;
    logic [UTF8D_CPW-1:0] r_out_cp;
    logic                 r_out_err;
    logic                 r_out_last;
    logic                 r_hold_vld;
    logic [UTF8D_CPW-1:0] r_hold_cp;
    logic                 r_hold_err;

    logic                 w_out_free;
    logic                 w_active;
    logic [UTF8D_CPW-1:0] w_added;
    logic [7:0]           w_b;
    t_cls                 w_cls;

    // result slots of the item being popped
    logic                 w_r0_vld, w_r0_err;
    logic [UTF8D_CPW-1:0] w_r0_cp;
    logic                 w_r1_vld, w_r1_err;
    logic [UTF8D_CPW-1:0] w_r1_cp;

    // lead-byte decode
    logic                 w_l_emit, w_l_err, w_l_pv_ld;
    logic [UTF8D_CPW-1:0] w_l_pv;
    t_mode                w_l_mode;

    assign w_b        = i_q_ent.data_byte;
    assign w_cls      = i_q_ent.cls;
    assign w_out_free = !r_out_vld || o_cp_if.ready;
    assign o_q_pop    = i_q_valid && !r_hold_vld && w_out_free;
    assign w_added    = {r_pv[UTF8D_CPW-7:0], w_b[5:0]};

    always_comb begin
        case (r_mode)
            MODE_ERR1, MODE_ERR2, MODE_ERR3, MODE_ERR4, MODE_ERR5,
            MODE_APP1, MODE_APP2, MODE_APP3,
            MODE_E0, MODE_ED, MODE_F0, MODE_F4: w_active = 1'b1;
            default:                            w_active = 1'b0;
        endcase
    end

    always_comb begin
        w_l_emit  = 1'b0;
        w_l_err   = 1'b0;
        w_l_pv_ld = 1'b0;
        w_l_pv    = '0;
        w_l_mode  = MODE_START;
        case (w_cls)
            CLS_ASCII: w_l_emit = 1'b1;
            CLS_CONT, CLS_FEFF: begin
                w_l_emit = 1'b1;
                w_l_err  = 1'b1;
            end
            CLS_C0C1:  w_l_mode = MODE_ERR1;
            CLS_LEAD2: begin
                w_l_pv_ld = 1'b1;
                w_l_pv    = {16'd0, w_b[4:0]};
                w_l_mode  = MODE_APP1;
            end
            CLS_E0: begin
                w_l_pv_ld = 1'b1;
                w_l_mode  = MODE_E0;
            end
            CLS_ED: begin
                w_l_pv_ld = 1'b1;
                w_l_pv    = 21'h00000D;
                w_l_mode  = MODE_ED;
            end
            CLS_LEAD3: begin
                w_l_pv_ld = 1'b1;
                w_l_pv    = {17'd0, w_b[3:0]};
                w_l_mode  = MODE_APP2;
            end
            CLS_F0: begin
                w_l_pv_ld = 1'b1;
                w_l_mode  = MODE_F0;
            end
            CLS_LEAD4: begin
                w_l_pv_ld = 1'b1;
                w_l_pv    = {19'd0, w_b[1:0]};
                w_l_mode  = MODE_APP3;
            end
            CLS_F4: begin
                w_l_pv_ld = 1'b1;
                w_l_pv    = 21'h000004;
                w_l_mode  = MODE_F4;
            end
            CLS_F5F7:  w_l_mode = MODE_ERR3;
            CLS_F8FB:  w_l_mode = MODE_ERR4;
            CLS_FCFD:  w_l_mode = MODE_ERR5;
            default:   w_l_mode = MODE_START;
        endcase
    end

    always_comb begin
        n_mode   = r_mode;
        n_pv     = r_pv;
        w_r0_vld = 1'b0;
        w_r0_err = 1'b0;
        w_r0_cp  = i_repl;
        w_r1_vld = 1'b0;
        w_r1_err = 1'b0;
        w_r1_cp  = i_repl;
        if (o_q_pop) begin
            if (w_cls == CLS_EOS) begin
                w_r0_vld = w_active;
                w_r0_err = 1'b1;
                n_mode   = MODE_START;
            end else if (!w_active) begin
                w_r0_vld = w_l_emit;
                w_r0_err = w_l_err;
                w_r0_cp  = w_l_err ? i_repl : {13'd0, w_b};
                n_mode   = w_l_mode;
                if (w_l_pv_ld) begin
                    n_pv = w_l_pv;
                end
            end else if (w_cls == CLS_CONT) begin
                case (r_mode)
                    MODE_ERR1: begin
                        w_r0_vld = 1'b1;
                        w_r0_err = 1'b1;
                        n_mode   = MODE_START;
                    end
                    MODE_ERR2: n_mode = MODE_ERR1;
                    MODE_ERR3: n_mode = MODE_ERR2;
                    MODE_ERR4: n_mode = MODE_ERR3;
                    MODE_ERR5: n_mode = MODE_ERR4;
                    MODE_APP1: begin
                        n_pv     = w_added;
                        w_r0_vld = 1'b1;
                        w_r0_cp  = w_added;
                        n_mode   = MODE_START;
                    end
                    MODE_APP2: begin
                        n_pv   = w_added;
                        n_mode = MODE_APP1;
                    end
                    MODE_APP3: begin
                        n_pv   = w_added;
                        n_mode = MODE_APP2;
                    end
                    MODE_E0: begin
                        if (w_b <= 8'h9F) begin
                            n_mode = MODE_ERR1;
                        end else begin
                            n_pv   = w_added;
                            n_mode = MODE_APP1;
                        end
                    end
                    MODE_ED: begin
                        if (w_b <= 8'h9F) begin
                            n_pv   = w_added;
                            n_mode = MODE_APP1;
                        end else begin
                            n_mode = MODE_ERR1;
                        end
                    end
                    MODE_F0: begin
                        if (w_b <= 8'h8F) begin
                            n_mode = MODE_ERR2;
                        end else begin
                            n_pv   = w_added;
                            n_mode = MODE_APP2;
                        end
                    end
                    MODE_F4: begin
                        if (w_b <= 8'h8F) begin
                            n_pv   = w_added;
                            n_mode = MODE_APP2;
                        end else begin
                            n_mode = MODE_ERR2;
                        end
                    end
                    default: n_mode = MODE_START;
                endcase
            end else begin
                // sequence cut short: replace, then decode the byte afresh
                w_r0_vld = 1'b1;
                w_r0_err = 1'b1;
                w_r1_vld = w_l_emit;
                w_r1_err = w_l_err;
                w_r1_cp  = w_l_err ? i_repl : {13'd0, w_b};
                n_mode   = w_l_mode;
                if (w_l_pv_ld) begin
                    n_pv = w_l_pv;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_START;
            r_pv       <= '0;
            r_out_vld  <= 1'b0;
            r_hold_vld <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_pv   <= n_pv;
            if (w_out_free) begin
                if (r_hold_vld) begin
                    r_out_vld  <= 1'b1;
                    r_hold_vld <= 1'b0;
                end else begin
                    r_out_vld  <= w_r0_vld;
                    r_hold_vld <= w_r0_vld && w_r1_vld;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_hold_vld) begin
                r_out_cp   <= r_hold_cp;
                r_out_err  <= r_hold_err;
                r_out_last <= 1'b1;
            end else begin
                r_out_cp   <= w_r0_cp;
                r_out_err  <= w_r0_err;
                r_out_last <= !w_r1_vld;
                r_hold_cp  <= w_r1_cp;
                r_hold_err <= w_r1_err;
            end
        end
    end

    assign o_cp_if.valid       = r_out_vld;
    assign o_cp_if.code_point  = r_out_cp;
    assign o_cp_if.is_error    = r_out_err;
    assign o_cp_if.last_of_run = r_out_last;

endmodule

`default_nettype wire

@@ rtl/utf8_decoder_with_replacement.sv @@
// ----------------------------------------------------------------------------
// utf8_decoder_with_replacement
// UTF-8 byte stream to Unicode code points, malformed input replaced.
// ----------------------------------------------------------------------------
// One byte item (or end-of-stream item) is taken per cycle while the queue
// has room. A front end classifies each byte and pushes it into a four-entry
// queue; the decoder behind it pops one item per cycle unless its hold stage
// is full or the output is stalled, and drives a registered output with a
// one-entry hold stage, so the output side may stall without blocking input
// until the queue fills. Most items give one or no result; an item that ends
// a broken sequence and is then decoded afresh gives two results and holds
// the decoder until the second result has moved from the hold stage to the
// output register. The replacement code point sits at byte address 0 of the
// APB port (reset 0xFFFD) and must only be written while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_decoder_with_replacement (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    utf8d_byte_if.sink                              i_byte_if,
    utf8d_cp_if.source                              o_cp_if,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [utf8d_pkg::UTF8D_PAW-1:0]    paddr,
    input  wire logic [utf8d_pkg::UTF8D_PDW-1:0]    pwdata,
    output logic      [utf8d_pkg::UTF8D_PDW-1:0]    prdata,
    output logic                                    pready
);
    import utf8d_pkg::*;

    logic [UTF8D_CPW-1:0] r_repl;
    logic                 w_q_push;
    t_qent                w_push_ent;
    logic                 w_q_ready;
    logic                 w_q_pop;
    logic                 w_q_valid;
    t_qent                w_pop_ent;
    logic                 w_reg_sel;

    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[2] == REG_REPLACEMENT);
    assign prdata    = w_reg_sel ? {{(UTF8D_PDW-UTF8D_CPW){1'b0}}, r_repl} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repl <= UTF8D_REPL_RST;
        end else if (psel && penable && pwrite && pready && w_reg_sel) begin
            r_repl <= pwdata[UTF8D_CPW-1:0];
        end
    end

    utf8d_front u_front (
        .i_byte_if (i_byte_if),
        .i_q_ready (w_q_ready),
        .o_q_push  (w_q_push),
        .o_q_ent   (w_push_ent)
    );

    utf8d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_ent   (w_push_ent),
        .o_ready (w_q_ready),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_ent   (w_pop_ent)
    );

    utf8d_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_repl    (r_repl),
        .i_q_valid (w_q_valid),
        .i_q_ent   (w_pop_ent),
        .o_q_pop   (w_q_pop),
        .o_cp_if   (o_cp_if)
    );

endmodule

`default_nettype wire

@@ rtl/utf8d_checker.sv @@
// ----------------------------------------------------------------------------
// utf8d_checker
// Port-level checks on the decoder's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        i_ready,
    input  wire logic [20:0] i_code_point,
    input  wire logic        i_is_error,
    input  wire logic        i_last_of_run,
    input  wire logic [31:0] i_prdata,
    input  wire logic [2:0]  i_paddr
);

    // a stalled result must hold
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_code_point)
            && $stable(i_is_error) && $stable(i_last_of_run))
        else $error("result changed while stalled");

    // error items carry the programmed replacement value
    a_repl_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_is_error && (i_paddr[2] == 1'b0) |-> i_code_point == i_prdata[20:0])
        else $error("error item without replacement value");

    // decoded scalars are never surrogates nor beyond the Unicode range
    a_scalar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_is_error |->
            (i_code_point <= 21'h10FFFF)
            && !((i_code_point >= 21'h00D800) && (i_code_point <= 21'h00DFFF)))
        else $error("decoded value not a Unicode scalar");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid straight after reset");

endmodule

bind utf8_decoder_with_replacement utf8d_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_cp_if.valid),
    .i_ready       (o_cp_if.ready),
    .i_code_point  (o_cp_if.code_point),
    .i_is_error    (o_cp_if.is_error),
    .i_last_of_run (o_cp_if.last_of_run),
    .i_prdata      (prdata),
    .i_paddr       (paddr)
);

`default_nettype wire
